// ----- hw/rtl/othd_pkg.sv -----
// Package for the octal text to hex decoder: queue entry type, queue sizing,
// character constants and the character mapping functions.
// No dependencies; every other file of the block imports it.
package othd_pkg;

  localparam int unsigned GROUP_DIGITS = 7;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned GROUP_W = 23;

  localparam logic [7:0] CHAR_ONE = 8'h31;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    KIND_OPEN,
    KIND_NIBBLE,
    KIND_GROUP
  } entry_kind_e;

  typedef struct packed {
    entry_kind_e          kind;
    logic [GROUP_W-1:0]   payload;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // '0'-'9' and 'A'-'F' give their digit value, every other character 0.
  function automatic logic [3:0] digit_of(input logic [7:0] ch);
    logic [3:0] d;
    d = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = 4'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      d = 4'(ch - 8'h37);
    end
    return d;
  endfunction

  // Upper-case hex character of a value; values above 15 give byte 0.
  function automatic logic [7:0] nibble_char(input logic [6:0] v);
    logic [7:0] c;
    c = 8'd0;
    if (v <= 7'd9) begin
      c = 8'h30 + {1'b0, v};
    end else if (v <= 7'd15) begin
      c = 8'h37 + {1'b0, v};
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/othd_queue.sv -----
// Short queue of work entries between the decoder front and back.
// Depends on othd_pkg for the entry type and the queue depth.
module othd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  othd_pkg::entry_t       entry_i,
  input  logic                   pop_i,
  output othd_pkg::entry_t       entry_o,
  output othd_pkg::queue_status_t status_o
);
  import othd_pkg::*;

  entry_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign entry_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- hw/rtl/othd_front.sv -----
// Decoder front: accepts text characters, tracks mode and buffer state,
// regroups digits into nibbles and collects digit groups for the back.
// Depends on othd_pkg.
module othd_front #(
  parameter int unsigned GroupDigits = othd_pkg::GROUP_DIGITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       text_char_i,
  input  logic             is_mode_i,
  input  logic             is_final_i,
  input  logic             q_full_i,
  output logic             push_o,
  output othd_pkg::entry_t entry_o
);
  import othd_pkg::*;

  localparam logic [2:0] GroupDigitsW = 3'(GroupDigits);
  localparam logic       SingleDigit  = (GroupDigits < 2);

  logic                group_mode_q;
  logic                halted_q;
  logic [6:0]          bit_acc_q;
  logic [2:0]          bits_held_q;
  logic [GROUP_W-1:0]  group_q;
  logic [2:0]          digits_q;

  logic                accept;
  logic [3:0]          digit;
  logic [6:0]          rg_c;
  logic [3:0]          rg_nb;
  logic [2:0]          rg_sh;
  logic                rg_emit;
  logic [6:0]          rg_nib;
  logic [6:0]          rg_mask;
  logic [GROUP_W-1:0]  gv_next;
  logic [2:0]          cnt_next;
  logic                grp_done;
  logic                grp_decode;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign digit      = digit_of(text_char_i);

  // Bit regroup path.
  assign rg_c    = 7'({bit_acc_q, 3'b000} | {6'b0, digit});
  assign rg_nb   = {1'b0, bits_held_q} + 4'd3;
  assign rg_sh   = 3'(rg_nb - 4'd4);
  assign rg_emit = (rg_nb >= 4'd4);
  assign rg_nib  = rg_c >> rg_sh;

  always_comb begin
    unique case (rg_sh)
      3'd1:    rg_mask = 7'h01;
      3'd2:    rg_mask = 7'h03;
      3'd3:    rg_mask = 7'h07;
      default: rg_mask = 7'h00;
    endcase
  end

  // Group path.
  assign gv_next    = {group_q[GROUP_W-4:0], 3'b000} + {{(GROUP_W-4){1'b0}}, digit};
  assign cnt_next   = digits_q + 3'd1;
  assign grp_done   = (cnt_next >= GroupDigitsW);
  // A single-digit group completed by the final character is not decoded.
  assign grp_decode = grp_done && !(is_final_i && SingleDigit);

  always_comb begin
    push_o          = 1'b0;
    entry_o.kind    = KIND_OPEN;
    entry_o.payload = '0;
    if (accept) begin
      if (is_mode_i) begin
        push_o = 1'b1;
      end else if (!halted_q) begin
        if (!group_mode_q) begin
          if (rg_emit) begin
            push_o          = 1'b1;
            entry_o.kind    = KIND_NIBBLE;
            entry_o.payload = {{(GROUP_W-8){1'b0}}, nibble_char(rg_nib)};
          end
        end else if (grp_decode) begin
          push_o          = 1'b1;
          entry_o.kind    = KIND_GROUP;
          entry_o.payload = gv_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_mode_q <= 1'b0;
      halted_q     <= 1'b1;
      bit_acc_q    <= '0;
      bits_held_q  <= '0;
      group_q      <= '0;
      digits_q     <= '0;
    end else if (accept) begin
      if (is_mode_i) begin
        group_mode_q <= (text_char_i != CHAR_ONE);
        halted_q     <= is_final_i;
        bit_acc_q    <= '0;
        bits_held_q  <= '0;
        group_q      <= '0;
        digits_q     <= '0;
      end else if (!halted_q) begin
        // The final character closes the buffer and drops leftover work.
        if (is_final_i) begin
          halted_q    <= 1'b1;
          bit_acc_q   <= '0;
          bits_held_q <= '0;
          group_q     <= '0;
          digits_q    <= '0;
        end else if (!group_mode_q) begin
          if (rg_emit) begin
            bit_acc_q   <= rg_c & rg_mask;
            bits_held_q <= rg_sh;
          end else begin
            bit_acc_q   <= rg_c;
            bits_held_q <= rg_nb[2:0];
          end
        end else if (grp_done) begin
          group_q  <= '0;
          digits_q <= '0;
        end else begin
          group_q  <= gv_next;
          digits_q <= cnt_next;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/othd_back.sv -----
// Decoder back: pops queue entries, splits digit groups into base-100 parts
// through a three-step reciprocal divider and emits hex characters.
// Depends on othd_pkg.
module othd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  othd_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_data_o,
  output logic             out_last_o
);
  import othd_pkg::*;

  // floor(c / 100) = (c * RECIP_HI) >> 30 for every 23-bit c, and
  // floor(q / 100) = (q * RECIP_LO) >> 24 for every quotient q of that.
  localparam logic [23:0] RECIP_HI = 24'd10737419;
  localparam logic [17:0] RECIP_LO = 18'd167773;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV1,
    B_DIV2,
    B_DIV3,
    B_EMIT
  } back_state_e;

  back_state_e         state_q;
  logic                stop_q;
  logic [2:0]          idx_q;
  logic                out_valid_q;
  logic [7:0]          out_data_q;
  logic                out_last_q;

  logic [GROUP_W-1:0]  c_q;
  logic [16:0]         q_q;
  logic [9:0]          q2_q;
  logic [6:0]          c2_q;
  logic [6:0]          c3_q;

  logic                out_free;
  logic                out_load;
  logic [46:0]         prod_hi;
  logic [34:0]         prod_lo;
  logic [23:0]         q_x100;
  logic [16:0]         q2_x100;
  logic [7:0]          byte1, byte2, byte3, sel_byte;
  logic [3:0]          nib;
  logic [7:0]          emit_char;
  logic [2:0]          last_idx;

  function automatic logic [7:0] part_byte(input logic [9:0] v);
    logic [9:0] s;
    s = v + 10'd30;
    return (v == 10'd1) ? 8'h09 : s[7:0];
  endfunction

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == B_IDLE) && !q_empty_i &&
                    ((entry_i.kind != KIND_NIBBLE) || out_free);
  // The output register takes a new character from a nibble entry or an emit step.
  assign out_load = (pop_o && (entry_i.kind == KIND_NIBBLE)) ||
                    ((state_q == B_EMIT) && out_free);

  assign prod_hi = 47'(c_q) * 47'(RECIP_HI);
  assign prod_lo = 35'(q_q) * 35'(RECIP_LO);
  assign q_x100  = 24'(q_q) * 24'd100;
  assign q2_x100 = 17'(q2_q) * 17'd100;

  assign byte1 = part_byte(q2_q);
  assign byte2 = part_byte({3'b000, c2_q});
  assign byte3 = part_byte({3'b000, c3_q});

  always_comb begin
    unique case (idx_q[2:1])
      2'd0:    sel_byte = byte1;
      2'd1:    sel_byte = byte2;
      default: sel_byte = byte3;
    endcase
  end

  assign nib       = idx_q[0] ? sel_byte[3:0] : sel_byte[7:4];
  assign emit_char = nibble_char({3'b000, nib});
  // A zero middle part stops after the first byte, a zero low part after two.
  assign last_idx  = (c2_q == '0) ? 3'd1 : ((c3_q == '0) ? 3'd3 : 3'd5);

  always_ff @(posedge clk_i) begin
    if (pop_o && (entry_i.kind == KIND_GROUP)) begin
      c_q <= entry_i.payload;
    end
    unique case (state_q)
      B_DIV1: begin
        q_q <= prod_hi[46:30];
      end
      B_DIV2: begin
        c3_q <= 7'({1'b0, c_q} - q_x100);
        q2_q <= prod_lo[33:24];
      end
      B_DIV3: begin
        c2_q <= 7'(q_q - q2_x100);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      stop_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            unique case (entry_i.kind)
              KIND_OPEN: begin
                stop_q <= 1'b0;
              end
              KIND_NIBBLE: begin
                out_data_q  <= entry_i.payload[7:0];
                out_last_q  <= 1'b1;
              end
              KIND_GROUP: begin
                if (!stop_q) begin
                  state_q <= B_DIV1;
                  idx_q   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        B_DIV1: state_q <= B_DIV2;
        B_DIV2: state_q <= B_DIV3;
        B_DIV3: state_q <= B_EMIT;
        B_EMIT: begin
          if (out_free) begin
            out_data_q  <= emit_char;
            out_last_q  <= (idx_q == last_idx);
            idx_q       <= idx_q + 3'd1;
            if (idx_q == last_idx) begin
              state_q <= B_IDLE;
              stop_q  <= (last_idx != 3'd5);
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- hw/rtl/octal_text_to_hex_decoder.sv -----
// Top level of the octal text to hex decoder: front, work queue and back.
// Depends on othd_pkg, othd_front, othd_queue and othd_back.
//
// Usage: characters of a text buffer enter on the slave stream, one per
// transaction. tuser marks the buffer's first character, which selects the
// mode ('1' selects bit regroup, anything else group mode) and gives no
// output; tlast marks the buffer's last character. Hex characters leave on
// the master stream, and tlast there marks the last character caused by one
// input transaction.
//
// Throughput: the front takes one character per cycle as long as the
// four-entry work queue has room. In bit regroup mode the back turns one
// queue entry into one output per cycle while the receiver takes them, so a
// character flows through at one per cycle; the hex character of a character
// that completes a nibble passes through the queue and the output register.
// In group mode the back takes a finished group from the queue, runs the
// reciprocal division in B_DIV1, B_DIV2 and B_DIV3 and then emits two, four
// or six hex characters, one per cycle while the receiver takes them, before
// it takes another entry.
//
// Reset leaves the block with no buffer open: characters are ignored until a
// first character arrives. When the receiver stalls, the output register
// holds its transaction, the back waits and the queue fills; once it is full
// s_axis_tready drops until the back takes an entry.
module octal_text_to_hex_decoder #(
  parameter int unsigned GROUP_DIGITS = othd_pkg::GROUP_DIGITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_char
  input  logic [0:0] s_axis_tuser,   // [0] is_mode_char
  input  logic       s_axis_tlast,   // is_final_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] hex_char
  output logic       m_axis_tlast    // last_of_run
);
  import othd_pkg::*;

  logic          push;
  logic          pop;
  entry_t        push_entry;
  entry_t        head_entry;
  queue_status_t q_status;

  // The front classifies each character and posts work for the back.
  othd_front #(
    .GroupDigits (GROUP_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .text_char_i (s_axis_tdata),
    .is_mode_i   (s_axis_tuser[0]),
    .is_final_i  (s_axis_tlast),
    .q_full_i    (q_status.full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // The queue lets the front run ahead while the back divides or stalls.
  othd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  // The back emits hex characters through its output register.
  othd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_status.empty),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // The front never posts into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full))
    else $error("work posted into a full queue");

  // The back never takes from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_status.empty))
    else $error("work taken from an empty queue");

  // Input backpressure only starts right after the front posted work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(push))
    else $error("input ready dropped without new queued work");

endmodule
